### hdl/tvsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvsg_pkg: shared types and constants of the three-voice sound generator
// Item formats, operation codes, register map and per-chip control structs.
// ----------------------------------------------------------------------------
package tvsg_pkg;

	// Default number of chips; the result fields have room for two.
	localparam int NUM_CHIPS_DEF = 2;
	localparam int OUT_CHIPS     = 2;
	localparam int NUM_VOICES    = 3;

	typedef enum logic [1:0] {
		OP_WRITE     = 2'd0,
		OP_TONE_TICK = 2'd1,
		OP_ENV_TICK  = 2'd2,
		OP_NONE      = 2'd3
	} op_t;

	// Register map of one chip.
	localparam logic [3:0] REG_TONE_A_LO    = 4'd0;
	localparam logic [3:0] REG_TONE_A_HI    = 4'd1;
	localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
	localparam logic [3:0] REG_MIXER        = 4'd7;
	localparam logic [3:0] REG_AMP_A        = 4'd8;
	localparam logic [3:0] REG_ENV_LO       = 4'd11;
	localparam logic [3:0] REG_ENV_HI       = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

	typedef struct packed {
		op_t        op;
		logic       chip;
		logic [3:0] reg_index;
		logic [7:0] write_data;
	} cmd_item_t;

	typedef struct packed {
		logic [5:0]  tone_bits;
		logic [1:0]  noise_bits;
		logic [5:0]  tone_enables;
		logic [5:0]  noise_enables;
		logic [23:0] channel_levels;
		logic [7:0]  envelope_levels;
	} snd_item_t;

	// Control for one chip during the cycle an item is applied.
	typedef struct packed {
		logic       wr;
		logic       tick_tn;
		logic       tick_env;
		logic [3:0] reg_index;
		logic [7:0] data;
	} chip_cmd_t;

	// Post-update view of one chip.
	typedef struct packed {
		logic [NUM_VOICES-1:0]      tone;
		logic                       noise;
		logic [NUM_VOICES-1:0]      tone_en;
		logic [NUM_VOICES-1:0]      noise_en;
		logic [NUM_VOICES-1:0][3:0] levels;
		logic [3:0]                 env_level;
	} chip_stat_t;

endpackage
`default_nettype wire

### hdl/tvsg_env.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvsg_env: envelope generator of one chip
// Period prescaler and the attack/decay/hold/alternate level machine.
// ----------------------------------------------------------------------------
module tvsg_env (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tvsg_pkg::chip_cmd_t cmd,
	output logic [3:0]               level_d
);

	localparam int SH_HOLD = 0;
	localparam int SH_ALT  = 1;
	localparam int SH_ATT  = 2;
	localparam int SH_CONT = 3;

	logic [15:0] per_q, per_d;
	logic [3:0]  shape_q, shape_d;
	logic [15:0] cnt_q, cnt_d;
	logic [3:0]  level_q;
	logic        hold_q, hold_d;
	logic        rise_q, rise_d;

	always_comb begin
		logic [15:0] cnt_inc;
		logic        at_end;
		per_d   = per_q;
		shape_d = shape_q;
		cnt_d   = cnt_q;
		level_d = level_q;
		hold_d  = hold_q;
		rise_d  = rise_q;
		cnt_inc = cnt_q + 16'd1;
		at_end  = 1'b0;
		if (cmd.wr) begin
			unique case (cmd.reg_index)
				tvsg_pkg::REG_ENV_LO: per_d[7:0] = cmd.data;
				tvsg_pkg::REG_ENV_HI: per_d[15:8] = cmd.data;
				tvsg_pkg::REG_ENV_SHAPE: begin
					shape_d = cmd.data[3:0];
					cnt_d   = '0;
					hold_d  = 1'b0;
					rise_d  = cmd.data[SH_ATT];
					level_d = cmd.data[SH_ATT] ? 4'h0 : 4'hF;
				end
				default: ;
			endcase
		end
		if (cmd.tick_env && per_q != 16'd0) begin
			cnt_d = cnt_inc;
			if (!(cnt_inc < (per_q >> 4))) begin
				cnt_d = '0;
				if (!hold_q) begin
					if (rise_q) begin
						at_end = (level_q == 4'hF);
						if (!at_end) level_d = level_q + 4'd1;
					end else begin
						at_end = (level_q == 4'h0);
						if (!at_end) level_d = level_q - 4'd1;
					end
					if (at_end) begin
						if (!shape_q[SH_CONT]) begin
							level_d = 4'h0;
							hold_d  = 1'b1;
						end else if (shape_q[SH_HOLD]) begin
							level_d = (shape_q[SH_ATT] != shape_q[SH_ALT]) ? 4'hF : 4'h0;
							hold_d  = 1'b1;
						end else if (shape_q[SH_ALT]) begin
							rise_d = ~rise_q;
						end else begin
							level_d = shape_q[SH_ATT] ? 4'h0 : 4'hF;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q   <= '0;
			shape_q <= '0;
			cnt_q   <= '0;
			level_q <= '0;
			hold_q  <= 1'b0;
			rise_q  <= 1'b0;
		end else begin
			per_q   <= per_d;
			shape_q <= shape_d;
			cnt_q   <= cnt_d;
			level_q <= level_d;
			hold_q  <= hold_d;
			rise_q  <= rise_d;
		end
	end

	// A held envelope always rests at one of the two end levels.
	a_hold_level: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> (level_q == 4'h0 || level_q == 4'hF))
		else $error("envelope holding at a level other than 0 or 15");

endmodule
`default_nettype wire

### hdl/tvsg_chip.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvsg_chip: one sound generator chip
// Register decode, three tone dividers, noise generator and level select.
// ----------------------------------------------------------------------------
module tvsg_chip (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tvsg_pkg::chip_cmd_t  cmd,
	output tvsg_pkg::chip_stat_t      stat
);

	localparam int NV = tvsg_pkg::NUM_VOICES;

	logic [NV-1:0][11:0] tone_raw_q, tone_raw_d;
	logic [NV-1:0][11:0] tone_cnt_q, tone_cnt_d;
	logic [NV-1:0][11:0] tone_per;
	logic [NV-1:0]       tone_out_q, tone_out_d;
	logic [NV-1:0]       amp_env_q, amp_env_d;
	logic [NV-1:0][3:0]  fixed_q, fixed_d;
	logic [4:0]          noise_per_q, noise_per_d;
	logic [4:0]          noise_cnt_q, noise_cnt_d;
	logic [16:0]         noise_sh_q, noise_sh_d;
	logic                noise_out_q, noise_out_d;
	logic [5:0]          mixer_q, mixer_d;
	logic [3:0]          env_level_d;

	tvsg_env u_env (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.level_d (env_level_d)
	);

	always_comb begin
		tone_raw_d  = tone_raw_q;
		tone_cnt_d  = tone_cnt_q;
		tone_out_d  = tone_out_q;
		amp_env_d   = amp_env_q;
		fixed_d     = fixed_q;
		noise_per_d = noise_per_q;
		noise_cnt_d = noise_cnt_q;
		noise_sh_d  = noise_sh_q;
		noise_out_d = noise_out_q;
		mixer_d     = mixer_q;
		// A period of zero behaves as one.
		for (int i = 0; i < NV; i++) begin
			tone_per[i] = (tone_raw_q[i] == 12'd0) ? 12'd1 : tone_raw_q[i];
		end
		if (cmd.wr) begin
			for (int i = 0; i < NV; i++) begin
				if (cmd.reg_index == tvsg_pkg::REG_TONE_A_LO + 4'(2 * i))
					tone_raw_d[i][7:0] = cmd.data;
				if (cmd.reg_index == tvsg_pkg::REG_TONE_A_HI + 4'(2 * i))
					tone_raw_d[i][11:8] = cmd.data[3:0];
				if (cmd.reg_index == tvsg_pkg::REG_AMP_A + 4'(i)) begin
					amp_env_d[i] = cmd.data[4];
					fixed_d[i]   = cmd.data[3:0];
				end
			end
			if (cmd.reg_index == tvsg_pkg::REG_NOISE_PERIOD)
				noise_per_d = (cmd.data[4:0] == 5'd0) ? 5'd1 : cmd.data[4:0];
			if (cmd.reg_index == tvsg_pkg::REG_MIXER)
				mixer_d = cmd.data[5:0];
		end
		if (cmd.tick_tn) begin
			for (int i = 0; i < NV; i++) begin
				if (tone_cnt_q[i] != 12'd0) begin
					tone_cnt_d[i] = tone_cnt_q[i] - 12'd1;
					if (tone_cnt_d[i] == (tone_per[i] >> 1))
						tone_out_d[i] = ~tone_out_q[i];
				end else begin
					tone_cnt_d[i] = tone_per[i];
					tone_out_d[i] = ~tone_out_q[i];
				end
			end
			if (noise_cnt_q <= 5'd1) begin
				noise_cnt_d = noise_per_q;
				noise_sh_d  = {noise_sh_q[0] ^ noise_sh_q[3], noise_sh_q[16:1]};
				noise_out_d = noise_sh_q[1];
			end else begin
				noise_cnt_d = noise_cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_raw_q  <= '0;
			for (int i = 0; i < NV; i++) tone_cnt_q[i] <= 12'd1;
			tone_out_q  <= '0;
			amp_env_q   <= '0;
			fixed_q     <= '0;
			noise_per_q <= 5'd1;
			noise_cnt_q <= 5'd1;
			noise_sh_q  <= 17'd1;
			noise_out_q <= 1'b0;
			mixer_q     <= '0;
		end else begin
			tone_raw_q  <= tone_raw_d;
			tone_cnt_q  <= tone_cnt_d;
			tone_out_q  <= tone_out_d;
			amp_env_q   <= amp_env_d;
			fixed_q     <= fixed_d;
			noise_per_q <= noise_per_d;
			noise_cnt_q <= noise_cnt_d;
			noise_sh_q  <= noise_sh_d;
			noise_out_q <= noise_out_d;
			mixer_q     <= mixer_d;
		end
	end

	always_comb begin
		stat.tone      = tone_out_d;
		stat.noise     = noise_out_d;
		stat.tone_en   = ~mixer_d[2:0];
		stat.noise_en  = ~mixer_d[5:3];
		stat.env_level = env_level_d;
		for (int i = 0; i < NV; i++) begin
			stat.levels[i] = amp_env_d[i] ? env_level_d : fixed_d[i];
		end
	end

endmodule
`default_nettype wire

### hdl/three_voice_sound_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_voice_sound_generator_core: two-chip, three-voice sound generator
// Register writes, tone/noise ticks and envelope ticks in; channel state out.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while cmd_stall is low and
// returns exactly one result item for each. An accepted item waits in the
// input register; then the per-chip next-state logic (tone dividers, noise
// shifter, envelope machine) writes the chip state and the result register
// together. The result reflects the state after the item is
// applied. A write item targets one chip; tick items step every chip. A held
// envelope on one chip never stops the others. Writes to a chip number at or
// above NUM_CHIPS are ignored. Only the first two chips appear in the result
// fields, so at most two chips are built. No clearing pass follows reset.
module three_voice_sound_generator_core #(
	parameter int NUM_CHIPS = tvsg_pkg::NUM_CHIPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire tvsg_pkg::cmd_item_t cmd,
	output logic                     snd_valid,
	input  wire logic                snd_stall,
	output tvsg_pkg::snd_item_t      snd
);

	localparam int NV = tvsg_pkg::NUM_VOICES;
	// Chips beyond the reported ones have no visible effect.
	localparam int LIVE_CHIPS = (NUM_CHIPS < tvsg_pkg::OUT_CHIPS) ?
		NUM_CHIPS : tvsg_pkg::OUT_CHIPS;

	tvsg_pkg::cmd_item_t  item_s1;
	logic                 valid_s1;
	tvsg_pkg::snd_item_t  snd_q;
	logic                 snd_valid_q;
	tvsg_pkg::snd_item_t  res;
	tvsg_pkg::chip_cmd_t  ccmd [LIVE_CHIPS];
	tvsg_pkg::chip_stat_t cstat [LIVE_CHIPS];
	logic                 accept;
	logic                 adv;

	// The input register may fill while a finished result waits downstream;
	// an item leaves it only when the result register is free or emptying.
	assign adv       = valid_s1 && (!snd_valid_q || !snd_stall);
	assign cmd_stall = valid_s1 && !adv;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
	end

	// Chip state changes only in the cycle an item moves to the result
	// register, so every item is applied exactly once.
	for (genvar c = 0; c < LIVE_CHIPS; c++) begin : g_chip
		always_comb begin
			ccmd[c].wr        = adv && (item_s1.op == tvsg_pkg::OP_WRITE) &&
			                    (item_s1.chip == 1'(c));
			ccmd[c].tick_tn   = adv && (item_s1.op == tvsg_pkg::OP_TONE_TICK);
			ccmd[c].tick_env  = adv && (item_s1.op == tvsg_pkg::OP_ENV_TICK);
			ccmd[c].reg_index = item_s1.reg_index;
			ccmd[c].data      = item_s1.write_data;
		end

		tvsg_chip u_chip (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (ccmd[c]),
			.stat   (cstat[c])
		);
	end

	// Pack the post-update chip views into the result fields; missing chips
	// read as zero.
	always_comb begin
		res = '0;
		for (int c = 0; c < LIVE_CHIPS; c++) begin
			res.tone_bits[NV*c +: NV]            = cstat[c].tone;
			res.noise_bits[c]                    = cstat[c].noise;
			res.tone_enables[NV*c +: NV]         = cstat[c].tone_en;
			res.noise_enables[NV*c +: NV]        = cstat[c].noise_en;
			res.channel_levels[4*NV*c +: 4*NV]   = cstat[c].levels;
			res.envelope_levels[4*c +: 4]        = cstat[c].env_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snd_valid_q <= 1'b0;
		end else if (adv) begin
			snd_valid_q <= 1'b1;
		end else if (!snd_stall) begin
			snd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			snd_q <= res;
		end
	end

	assign snd_valid = snd_valid_q;
	assign snd       = snd_q;

	// An accepted item is held in the input register on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach the input register");

	// An item that cannot move on stays put, unchanged.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("blocked item in the input register was lost or changed");

	// Every item that leaves the input register produces a result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> snd_valid_q)
		else $error("applied item produced no result");

endmodule
`default_nettype wire

### test/three_voice_sound_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_sound_generator_core_tb: self-checking bench for the sound core
// Sends register writes and tone, noise and envelope ticks under several
// handshake idling patterns. A behavioral copy of both chips predicts every
// result item, and each returned item is compared with it field by field.
// ----------------------------------------------------------------------------
module three_voice_sound_generator_core_tb;

	localparam int CHIPS  = tvsg_pkg::NUM_CHIPS_DEF;
	localparam int VOICES = tvsg_pkg::NUM_VOICES;

	// Registers that the package leaves unnamed.
	localparam logic [3:0] REG_TONE_B_LO = 4'd2;
	localparam logic [3:0] REG_TONE_B_HI = 4'd3;
	localparam logic [3:0] REG_TONE_C_LO = 4'd4;
	localparam logic [3:0] REG_TONE_C_HI = 4'd5;
	localparam logic [3:0] REG_AMP_B     = 4'd9;
	localparam logic [3:0] REG_AMP_C     = 4'd10;
	localparam logic [3:0] REG_SPARE_0   = 4'd14;
	localparam logic [3:0] REG_SPARE_1   = 4'd15;

	// Bit positions inside the envelope shape nibble and an amplitude byte.
	localparam int SHAPE_HOLD = 0;
	localparam int SHAPE_ALT  = 1;
	localparam int SHAPE_ATT  = 2;
	localparam int SHAPE_CONT = 3;
	localparam int AMP_USE_ENV = 4;

	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_CYCLES = 10;
	localparam int WANT_DEPTH   = 1024;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_stall;
	tvsg_pkg::cmd_item_t cmd;
	logic                snd_valid;
	logic                snd_stall = 1'b0;
	tvsg_pkg::snd_item_t snd;

	three_voice_sound_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.snd_valid (snd_valid),
		.snd_stall (snd_stall),
		.snd       (snd)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioral copy of both chips. It is advanced once per accepted item.
	// ------------------------------------------------------------------------
	logic [7:0]  reg_shadow   [CHIPS][16];
	logic [11:0] tone_period  [CHIPS][VOICES];
	logic [11:0] tone_count   [CHIPS][VOICES];
	logic        tone_out     [CHIPS][VOICES];
	logic        uses_env     [CHIPS][VOICES];
	logic [3:0]  fixed_level  [CHIPS][VOICES];
	logic [4:0]  noise_reload [CHIPS];
	logic [4:0]  noise_count  [CHIPS];
	logic [16:0] noise_lfsr   [CHIPS];
	logic        noise_out    [CHIPS];
	logic [7:0]  mixer        [CHIPS];
	logic [15:0] env_period   [CHIPS];
	logic [15:0] env_count    [CHIPS];
	logic [3:0]  env_shape    [CHIPS];
	logic [3:0]  env_level    [CHIPS];
	logic        env_holding  [CHIPS];
	logic        env_rising   [CHIPS];

	// Expected result items, oldest first, in a circular buffer.
	tvsg_pkg::snd_item_t want_fifo [WANT_DEPTH];
	int want_wr = 0;
	int want_rd = 0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int fault_count    = 0;
	int results_seen   = 0;
	int envelope_runs  = 0;
	int sent_by_op [4] = '{0, 0, 0, 0};

	task automatic clear_generators();
		for (int c = 0; c < CHIPS; c++) begin
			for (int r = 0; r < 16; r++)
				reg_shadow[c][r] = '0;
			for (int v = 0; v < VOICES; v++) begin
				tone_period[c][v] = 12'd1;
				tone_count[c][v]  = 12'd1;
				tone_out[c][v]    = 1'b0;
				uses_env[c][v]    = 1'b0;
				fixed_level[c][v] = '0;
			end
			noise_reload[c] = 5'd1;
			noise_count[c]  = 5'd1;
			noise_lfsr[c]   = 17'd1;
			noise_out[c]    = 1'b0;
			mixer[c]        = '0;
			env_period[c]   = '0;
			env_count[c]    = '0;
			env_shape[c]    = '0;
			env_level[c]    = '0;
			env_holding[c]  = 1'b0;
			env_rising[c]   = 1'b0;
		end
	endtask

	function automatic void write_register(int c, logic [3:0] r, logic [7:0] v);
		int         voice;
		logic [11:0] p;
		reg_shadow[c][r] = v;
		case (r)
			tvsg_pkg::REG_TONE_A_LO, tvsg_pkg::REG_TONE_A_HI, REG_TONE_B_LO,
			REG_TONE_B_HI, REG_TONE_C_LO, REG_TONE_C_HI: begin
				// Both halves of a pair rebuild the period; zero means one.
				voice = int'(r) / 2;
				p = {reg_shadow[c][2 * voice + 1][3:0], reg_shadow[c][2 * voice]};
				tone_period[c][voice] = (p == '0) ? 12'd1 : p;
			end
			tvsg_pkg::REG_NOISE_PERIOD: begin
				noise_reload[c] = (v[4:0] == '0) ? 5'd1 : v[4:0];
			end
			tvsg_pkg::REG_MIXER: begin
				mixer[c] = v;
			end
			tvsg_pkg::REG_AMP_A, REG_AMP_B, REG_AMP_C: begin
				voice = int'(r - tvsg_pkg::REG_AMP_A);
				uses_env[c][voice]    = v[AMP_USE_ENV];
				fixed_level[c][voice] = v[3:0];
			end
			tvsg_pkg::REG_ENV_LO: begin
				env_period[c][7:0] = v;
			end
			tvsg_pkg::REG_ENV_HI: begin
				env_period[c][15:8] = v;
			end
			tvsg_pkg::REG_ENV_SHAPE: begin
				// A shape write restarts the envelope from its first edge.
				env_shape[c]   = v[3:0];
				env_count[c]   = '0;
				env_holding[c] = 1'b0;
				env_rising[c]  = v[SHAPE_ATT];
				env_level[c]   = v[SHAPE_ATT] ? 4'd0 : 4'd15;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void step_tone_noise(int c);
		logic feedback;
		for (int v = 0; v < VOICES; v++) begin
			if (tone_count[c][v] != '0) begin
				tone_count[c][v] = tone_count[c][v] - 12'd1;
				if (tone_count[c][v] == (tone_period[c][v] >> 1))
					tone_out[c][v] = ~tone_out[c][v];
			end else begin
				tone_count[c][v] = tone_period[c][v];
				tone_out[c][v]   = ~tone_out[c][v];
			end
		end
		if (noise_count[c] <= 5'd1) begin
			feedback       = noise_lfsr[c][0] ^ noise_lfsr[c][3];
			noise_count[c] = noise_reload[c];
			noise_lfsr[c]  = {feedback, noise_lfsr[c][16:1]};
			noise_out[c]   = noise_lfsr[c][0];
		end else begin
			noise_count[c] = noise_count[c] - 5'd1;
		end
	endfunction

	function automatic void step_envelope(int c);
		logic at_end;
		if (env_period[c] == '0)
			return;
		env_count[c] = env_count[c] + 16'd1;
		if (env_count[c] < (env_period[c] >> 4))
			return;
		env_count[c] = '0;
		if (env_holding[c])
			return;
		if (env_rising[c]) begin
			at_end = (env_level[c] == 4'd15);
			if (!at_end)
				env_level[c] = env_level[c] + 4'd1;
		end else begin
			at_end = (env_level[c] == 4'd0);
			if (!at_end)
				env_level[c] = env_level[c] - 4'd1;
		end
		if (!at_end)
			return;
		if (!env_shape[c][SHAPE_CONT]) begin
			// One-shot shapes always settle at silence.
			env_level[c]   = 4'd0;
			env_holding[c] = 1'b1;
		end else if (env_shape[c][SHAPE_HOLD]) begin
			env_level[c] = (env_shape[c][SHAPE_ATT] != env_shape[c][SHAPE_ALT]) ?
				4'd15 : 4'd0;
			env_holding[c] = 1'b1;
		end else if (env_shape[c][SHAPE_ALT]) begin
			env_rising[c] = ~env_rising[c];
		end else begin
			env_level[c] = env_shape[c][SHAPE_ATT] ? 4'd0 : 4'd15;
		end
	endfunction

	// Applies one item to the copy and returns the result item it should cause.
	function automatic tvsg_pkg::snd_item_t sound_after(tvsg_pkg::cmd_item_t it);
		tvsg_pkg::snd_item_t s;
		int                  k;
		s = '0;
		case (it.op)
			tvsg_pkg::OP_WRITE: begin
				if (int'(it.chip) < CHIPS)
					write_register(int'(it.chip), it.reg_index, it.write_data);
			end
			tvsg_pkg::OP_TONE_TICK: begin
				for (int c = 0; c < CHIPS; c++)
					step_tone_noise(c);
			end
			tvsg_pkg::OP_ENV_TICK: begin
				for (int c = 0; c < CHIPS; c++)
					step_envelope(c);
			end
			default: begin
			end
		endcase
		for (int c = 0; c < CHIPS && c < tvsg_pkg::OUT_CHIPS; c++) begin
			for (int v = 0; v < VOICES; v++) begin
				k = VOICES * c + v;
				s.tone_bits[k]     = tone_out[c][v];
				s.tone_enables[k]  = ~mixer[c][v];
				s.noise_enables[k] = ~mixer[c][v + VOICES];
				s.channel_levels[4 * k +: 4] = uses_env[c][v] ? env_level[c] :
					fixed_level[c][v];
			end
			s.noise_bits[c] = noise_out[c];
			s.envelope_levels[4 * c +: 4] = env_level[c];
		end
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus side. The task is entered just after a rising edge; it may idle
	// for a few cycles, then offers the item and holds it until accepted. The
	// prediction is made at the edge of acceptance.
	// ------------------------------------------------------------------------
	task automatic offer_cmd(tvsg_pkg::cmd_item_t it);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		want_fifo[want_wr % WANT_DEPTH] = sound_after(it);
		want_wr++;
		sent_by_op[it.op]++;
	endtask

	function automatic tvsg_pkg::cmd_item_t write_item(logic chip, logic [3:0] r,
		logic [7:0] d);
		tvsg_pkg::cmd_item_t it;
		it.op         = tvsg_pkg::OP_WRITE;
		it.chip       = chip;
		it.reg_index  = r;
		it.write_data = d;
		return it;
	endfunction

	// Non-write items carry random junk in the unused fields.
	function automatic tvsg_pkg::cmd_item_t other_item(tvsg_pkg::op_t op);
		tvsg_pkg::cmd_item_t it;
		it.op         = op;
		it.chip       = 1'($urandom_range(1));
		it.reg_index  = 4'($urandom_range(15));
		it.write_data = 8'($urandom_range(255));
		return it;
	endfunction

	// Result side: the receiver stalls at random, as the current phase asks.
	always @(posedge clk)
		snd_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		tvsg_pkg::snd_item_t want;
		if (snd_valid === 1'b1 && snd_stall === 1'b0) begin
			results_seen++;
			if (want_wr == want_rd) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("%0t: result item with nothing pending: %h", $realtime, snd);
			end else begin
				want = want_fifo[want_rd % WANT_DEPTH];
				want_rd++;
				if (snd.tone_bits !== want.tone_bits ||
				    snd.noise_bits !== want.noise_bits ||
				    snd.tone_enables !== want.tone_enables ||
				    snd.noise_enables !== want.noise_enables ||
				    snd.channel_levels !== want.channel_levels ||
				    snd.envelope_levels !== want.envelope_levels) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("%0t: result %0d wrong (expected/actual): tone %h/%h noise %h/%h",
							$realtime, results_seen,
							want.tone_bits, snd.tone_bits,
							want.noise_bits, snd.noise_bits);
						$display("  tone_en %h/%h noise_en %h/%h levels %h/%h env %h/%h",
							want.tone_enables, snd.tone_enables,
							want.noise_enables, snd.noise_enables,
							want.channel_levels, snd.channel_levels,
							want.envelope_levels, snd.envelope_levels);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------

	// The unused operation must change nothing and only report the state.
	task automatic test_unused_op();
		tvsg_pkg::cmd_item_t it;
		it = '{op: tvsg_pkg::OP_NONE, chip: 1'b1, reg_index: 4'hF, write_data: 8'hFF};
		offer_cmd(it);
	endtask

	// Zero periods are forced to one; the upper nibble of a high byte is dropped.
	task automatic test_tone_periods();
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_TONE_A_LO, 8'h00));
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_TONE_A_HI, 8'h00));
		offer_cmd(write_item(1'b1, REG_TONE_B_LO, 8'hFF));
		offer_cmd(write_item(1'b1, REG_TONE_B_HI, 8'hFF));
		offer_cmd(write_item(1'b0, REG_TONE_C_LO, 8'h01));
		offer_cmd(write_item(1'b0, REG_TONE_C_HI, 8'hF0));
		offer_cmd(other_item(tvsg_pkg::OP_TONE_TICK));
		offer_cmd(other_item(tvsg_pkg::OP_TONE_TICK));
	endtask

	task automatic test_noise_and_mixer();
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_NOISE_PERIOD, 8'h00));
		offer_cmd(write_item(1'b1, tvsg_pkg::REG_NOISE_PERIOD, 8'hFF));
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_MIXER, 8'hFF));
		offer_cmd(write_item(1'b1, tvsg_pkg::REG_MIXER, 8'h00));
		offer_cmd(other_item(tvsg_pkg::OP_TONE_TICK));
	endtask

	// Envelope select, fixed levels, and the two registers that are only stored.
	task automatic test_amplitudes();
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_AMP_A, 8'h1F));
		offer_cmd(write_item(1'b1, REG_AMP_C, 8'h0F));
		offer_cmd(write_item(1'b0, REG_AMP_B, 8'hEF));
		offer_cmd(write_item(1'b1, REG_SPARE_0, 8'hAA));
		offer_cmd(write_item(1'b1, REG_SPARE_1, 8'h55));
	endtask

	// Chip 0 gets the longest period and a rising shape, chip 1 a period so
	// short that it steps on every tick.
	task automatic test_envelope_start();
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_ENV_HI, 8'hFF));
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_ENV_LO, 8'hFF));
		offer_cmd(write_item(1'b1, tvsg_pkg::REG_ENV_LO, 8'h01));
		offer_cmd(write_item(1'b1, tvsg_pkg::REG_ENV_SHAPE, 8'h0B));
		offer_cmd(write_item(1'b0, tvsg_pkg::REG_ENV_SHAPE, 8'hFF));
		offer_cmd(other_item(tvsg_pkg::OP_ENV_TICK));
		offer_cmd(other_item(tvsg_pkg::OP_ENV_TICK));
	endtask

	// ------------------------------------------------------------------------
	// Random traffic.
	// ------------------------------------------------------------------------

	// One loose item: any write, or a tick, now and then the unused operation.
	// High bytes of periods are mostly zero so that dividers and the envelope
	// actually move within a run of this length.
	task automatic random_item();
		int        pick;
		logic [3:0] r;
		logic [7:0] d;
		pick = $urandom_range(99);
		if (pick < 30) begin
			r = 4'($urandom_range(15));
			d = 8'($urandom_range(255));
			if ((r == tvsg_pkg::REG_TONE_A_HI || r == REG_TONE_B_HI ||
			     r == REG_TONE_C_HI) && $urandom_range(3) != 0)
				d = '0;
			if (r == tvsg_pkg::REG_ENV_HI && $urandom_range(4) != 0)
				d = '0;
			offer_cmd(write_item(1'($urandom_range(1)), r, d));
		end else if (pick < 62) begin
			offer_cmd(other_item(tvsg_pkg::OP_TONE_TICK));
		end else if (pick < 95) begin
			offer_cmd(other_item(tvsg_pkg::OP_ENV_TICK));
		end else begin
			offer_cmd(other_item(tvsg_pkg::OP_NONE));
		end
	endtask

	// A well-formed envelope run: short period, one voice on the envelope, a
	// random shape, then a random run of ticks, mostly envelope ticks.
	task automatic envelope_run();
		logic      chip;
		int        ticks;
		int        pick;
		chip  = 1'($urandom_range(1));
		ticks = $urandom_range(20, 45);
		offer_cmd(write_item(chip, tvsg_pkg::REG_ENV_LO, 8'($urandom_range(63))));
		offer_cmd(write_item(chip, tvsg_pkg::REG_ENV_HI, 8'h00));
		offer_cmd(write_item(chip, 4'(tvsg_pkg::REG_AMP_A + $urandom_range(2)),
			8'($urandom_range(255)) | 8'h10));
		offer_cmd(write_item(chip, tvsg_pkg::REG_ENV_SHAPE, 8'($urandom_range(255))));
		repeat (ticks) begin
			pick = $urandom_range(9);
			if (pick < 7)
				offer_cmd(other_item(tvsg_pkg::OP_ENV_TICK));
			else if (pick < 9)
				offer_cmd(other_item(tvsg_pkg::OP_TONE_TICK));
			else
				random_item();
		end
		envelope_runs++;
	endtask

	task automatic random_phase(int idle_pct, int stall_pct, int count);
		int start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = sent_by_op[0] + sent_by_op[1] + sent_by_op[2] + sent_by_op[3];
		while (sent_by_op[0] + sent_by_op[1] + sent_by_op[2] + sent_by_op[3] - start
		       < count) begin
			if ($urandom_range(2) == 0)
				envelope_run();
			else
				random_item();
		end
	endtask

	// Four idling patterns: none, sender only, receiver only, then both.
	task automatic test_random_traffic();
		random_phase(0, 0, 150);
		random_phase(52, 0, 150);
		random_phase(0, 52, 150);
		random_phase(25, 25, 150);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		cmd_valid <= 1'b0;
		cmd       <= '0;
		arst_n    <= 1'b0;
		clear_generators();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unused_op();
		test_tone_periods();
		test_noise_and_mixer();
		test_amplitudes();
		test_envelope_start();
		test_random_traffic();

		cmd_valid <= 1'b0;
		while (want_wr != want_rd)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d writes, %0d tone/noise ticks, %0d envelope ticks, %0d no-ops.",
			sent_by_op[tvsg_pkg::OP_WRITE], sent_by_op[tvsg_pkg::OP_TONE_TICK],
			sent_by_op[tvsg_pkg::OP_ENV_TICK], sent_by_op[tvsg_pkg::OP_NONE]);
		$display("Checked %0d results over four idling patterns, %0d envelope runs.",
			results_seen, envelope_runs);
		if (fault_count == 0 && want_wr == want_rd) begin
			$display("three_voice_sound_generator_core: match");
		end else begin
			$display("three_voice_sound_generator_core: mismatch");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#(4_000_000);
		$display("three_voice_sound_generator_core: mismatch");
		$finish;
	end

endmodule

### sim.f
hdl/tvsg_pkg.sv
hdl/tvsg_env.sv
hdl/tvsg_chip.sv
hdl/three_voice_sound_generator_core.sv
test/three_voice_sound_generator_core_tb.sv
